// ----- rtl/sbf_pkg.sv -----
// ---------------------------------------------------------------------------
// SMBIOS structure framer package
// Shared types, codes and sizes for the framer front end, queue and back end.
// ---------------------------------------------------------------------------
package sbf_pkg;

    // Default table size limit, in bytes
    localparam longint unsigned MAX_TABLE_BYTES_DEF = 64'd65536;

    // Record queue between front and back end (depth is a power of two)
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic CFG_WANTED_TYPE = 1'b0;
    localparam logic CFG_MATCH_EN    = 1'b1;

    // Record kinds (tuser)
    localparam logic REC_MATCH  = 1'b0;
    localparam logic REC_STATUS = 1'b1;

    // Minimum formatted area length (header only)
    localparam logic [7:0] HDR_LEN = 8'd4;

    // Parse phases
    typedef enum logic [2:0] {
        PH_TYPE = 3'd0,
        PH_LEN  = 3'd1,
        PH_HLO  = 3'd2,
        PH_HHI  = 3'd3,
        PH_FMT  = 3'd4,
        PH_STR  = 3'd5
    } phase_t;

    // Table status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT_LEN = 2'd1,
        ST_TRUNC     = 2'd2,
        ST_TOO_LONG  = 2'd3
    } status_t;

    // Live configuration
    typedef struct packed {
        logic [7:0] wanted_type;
        logic       match_enable;
    } cfg_t;

    // One queued entry: up to a match record and a status record for a byte
    typedef struct packed {
        logic        has_match;
        logic        has_status;
        logic [7:0]  struct_type;
        logic [15:0] struct_offset;
        logic [7:0]  struct_length;
        status_t     status;
    } entry_t;

endpackage

// ----- rtl/smbios_structure_framer.sv -----
// ---------------------------------------------------------------------------
// SMBIOS structure framer
// Parses a raw SMBIOS structure table and reports matching structures and
// the final table status.
// ---------------------------------------------------------------------------
//  Channel   Role      Transaction contents
//  s_axis    input     one table byte; tlast on the final byte
//  m_axis    output    one record; tuser = kind, tlast = last record of byte
//  cfg       write     wanted_type (index 0), match_enable (index 1)
//
//  One table byte is accepted per cycle; the front end's parse state update
//  sets that figure. A byte yields at most two records, played out by the
//  back end one per cycle while m_axis_tready is high, from a 4-entry queue.
//  s_axis_tready drops only when the queue is full. rst_n is asynchronous,
//  active low, and clears the parse state, the queue and both configuration registers.
// ---------------------------------------------------------------------------
module smbios_structure_framer #(
    parameter longint unsigned MAX_TABLE_BYTES = sbf_pkg::MAX_TABLE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] struct_type, [23:8] struct_offset,
                                        // [31:24] struct_length, [33:32] status, rest 0
    output logic        m_axis_tuser,   // [0] record_kind
    output logic        m_axis_tlast,   // last_of_run
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    sbf_pkg::cfg_t   cfg_reg, cfg_next;
    sbf_pkg::entry_t push_entry;
    sbf_pkg::entry_t pop_entry;
    logic            accept;
    logic            push_valid;
    logic            push_ready;
    logic            pop_valid;
    logic            pop_ready;
    logic [7:0]      struct_type;
    logic [15:0]     struct_offset;
    logic [7:0]      struct_length;
    logic [1:0]      status;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                sbf_pkg::CFG_WANTED_TYPE: cfg_next.wanted_type  = cfg_data;
                sbf_pkg::CFG_MATCH_EN:    cfg_next.match_enable = cfg_data[0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // Input handshake: a byte is taken whenever the queue has room
    assign s_axis_tready = push_ready;
    assign accept        = s_axis_tvalid && push_ready;

    sbf_front #(
        .MAX_TABLE_BYTES (MAX_TABLE_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_axis_tdata),
        .last_byte  (s_axis_tlast),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    sbf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    sbf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_entry     (pop_entry),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .record_kind   (m_axis_tuser),
        .struct_type   (struct_type),
        .struct_offset (struct_offset),
        .struct_length (struct_length),
        .status        (status),
        .last_of_run   (m_axis_tlast)
    );

    // Output packing
    assign m_axis_tdata = {6'd0, status, struct_length, struct_offset, struct_type};

endmodule

// ----- rtl/sbf_front.sv -----
// ---------------------------------------------------------------------------
// SMBIOS framer front end
// Walks the table byte by byte and queues record entries for completed
// matching structures and for the final table status.
// ---------------------------------------------------------------------------
module sbf_front #(
    parameter longint unsigned MAX_TABLE_BYTES = sbf_pkg::MAX_TABLE_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    input  sbf_pkg::cfg_t   cfg,
    output logic            push_valid,
    output sbf_pkg::entry_t push_entry
);

    localparam int POS_W = $clog2(MAX_TABLE_BYTES + 64'd1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_TABLE_BYTES);

    sbf_pkg::phase_t  phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       fmt_left_reg, fmt_left_next;
    logic [15:0]      start_reg, start_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       len_reg, len_next;
    logic             prev_zero_reg, prev_zero_next;
    sbf_pkg::status_t err_reg, err_next;

    logic              fmt_done;
    logic              complete;
    logic              type_hit;
    logic [POS_W+15:0] pos_wide;

    assign pos_wide = {16'd0, pos_reg};
    assign type_hit = cfg.match_enable && (type_reg == cfg.wanted_type);

    // Parser state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sbf_pkg::PH_TYPE;
            pos_reg       <= '0;
            fmt_left_reg  <= '0;
            start_reg     <= '0;
            type_reg      <= '0;
            len_reg       <= '0;
            prev_zero_reg <= 1'b0;
            err_reg       <= sbf_pkg::ST_OK;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            fmt_left_reg  <= fmt_left_next;
            start_reg     <= start_next;
            type_reg      <= type_next;
            len_reg       <= len_next;
            prev_zero_reg <= prev_zero_next;
            err_reg       <= err_next;
        end
    end

    // Next parse state and record classification
    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        fmt_left_next  = fmt_left_reg;
        start_next     = start_reg;
        type_next      = type_reg;
        len_next       = len_reg;
        prev_zero_next = prev_zero_reg;
        err_next       = err_reg;
        fmt_done       = 1'b0;
        complete       = 1'b0;
        push_valid     = 1'b0;
        push_entry     = '0;

        if (accept)
        begin
            if (err_reg == sbf_pkg::ST_OK)
            begin
                if (pos_reg >= MAX_POS)
                begin
                    err_next = sbf_pkg::ST_TOO_LONG;
                end
                else
                begin
                    unique case (phase_reg)
                        sbf_pkg::PH_TYPE:
                        begin
                            start_next = pos_wide[15:0];
                            type_next  = data_byte;
                            phase_next = sbf_pkg::PH_LEN;
                        end
                        sbf_pkg::PH_LEN:
                        begin
                            len_next = data_byte;
                            if (data_byte < sbf_pkg::HDR_LEN)
                                err_next = sbf_pkg::ST_SHORT_LEN;
                            else
                                phase_next = sbf_pkg::PH_HLO;
                        end
                        sbf_pkg::PH_HLO:
                        begin
                            phase_next = sbf_pkg::PH_HHI;
                        end
                        sbf_pkg::PH_HHI:
                        begin
                            fmt_left_next = len_reg - sbf_pkg::HDR_LEN;
                            if (len_reg == sbf_pkg::HDR_LEN)
                            begin
                                phase_next     = sbf_pkg::PH_STR;
                                prev_zero_next = 1'b0;
                                fmt_done       = 1'b1;
                            end
                            else
                            begin
                                phase_next = sbf_pkg::PH_FMT;
                            end
                        end
                        sbf_pkg::PH_FMT:
                        begin
                            fmt_left_next = fmt_left_reg - 8'd1;
                            if (fmt_left_reg == 8'd1)
                            begin
                                phase_next     = sbf_pkg::PH_STR;
                                prev_zero_next = 1'b0;
                                fmt_done       = 1'b1;
                            end
                        end
                        sbf_pkg::PH_STR:
                        begin
                            if (data_byte == 8'd0)
                            begin
                                if (prev_zero_reg)
                                begin
                                    complete       = 1'b1;
                                    phase_next     = sbf_pkg::PH_TYPE;
                                    prev_zero_next = 1'b0;
                                end
                                else
                                begin
                                    prev_zero_next = 1'b1;
                                end
                            end
                            else
                            begin
                                prev_zero_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            phase_next = sbf_pkg::PH_TYPE;
                        end
                    endcase
                    pos_next = pos_reg + POS_W'(1);
                end
            end

            // End of table: formatted area ending at the last byte still counts
            if (last_byte)
            begin
                if ((err_next == sbf_pkg::ST_OK) && (phase_next != sbf_pkg::PH_TYPE))
                begin
                    if (fmt_done)
                        complete = 1'b1;
                    else
                        err_next = sbf_pkg::ST_TRUNC;
                end
            end

            push_entry.has_match     = complete && type_hit;
            push_entry.has_status    = last_byte;
            push_entry.struct_type   = type_reg;
            push_entry.struct_offset = start_reg;
            push_entry.struct_length = len_reg;
            push_entry.status        = err_next;
            push_valid = push_entry.has_match || push_entry.has_status;

            // Table done: back to the reset parse state
            if (last_byte)
            begin
                phase_next     = sbf_pkg::PH_TYPE;
                pos_next       = '0;
                fmt_left_next  = '0;
                start_next     = '0;
                type_next      = '0;
                len_next       = '0;
                prev_zero_next = 1'b0;
                err_next       = sbf_pkg::ST_OK;
            end
        end
    end

endmodule

// ----- rtl/sbf_queue.sv -----
// ---------------------------------------------------------------------------
// SMBIOS framer record queue
// Small register FIFO of record entries between front and back end.
// ---------------------------------------------------------------------------
module sbf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  sbf_pkg::entry_t push_entry,
    output logic            push_ready,
    output logic            pop_valid,
    input  logic            pop_ready,
    output sbf_pkg::entry_t pop_entry
);

    localparam logic [sbf_pkg::QCNT_W-1:0] FULL_CNT = sbf_pkg::QCNT_W'(sbf_pkg::QUEUE_DEPTH);

    sbf_pkg::entry_t             mem_reg [sbf_pkg::QUEUE_DEPTH];
    logic [sbf_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [sbf_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [sbf_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update; pointers wrap at the power-of-two depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = wr_ptr_reg + sbf_pkg::QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + sbf_pkg::QPTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + sbf_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - sbf_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ----- rtl/sbf_back.sv -----
// ---------------------------------------------------------------------------
// SMBIOS framer back end
// Holds one queued entry in an output register and plays it out as a match
// record, a status record, or a match record followed by a status record.
// ---------------------------------------------------------------------------
module sbf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  sbf_pkg::entry_t pop_entry,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            record_kind,
    output logic [7:0]      struct_type,
    output logic [15:0]     struct_offset,
    output logic [7:0]      struct_length,
    output logic [1:0]      status,
    output logic            last_of_run
);

    sbf_pkg::entry_t cur_reg;
    logic            valid_reg, valid_next;
    logic            send_status_reg, send_status_next;
    logic            fire;
    logic            done;

    assign fire      = valid_reg && out_ready;
    assign done      = send_status_reg || !cur_reg.has_status;
    assign pop_ready = !valid_reg || (fire && done);
    assign out_valid = valid_reg;

    // Record fields from the held entry
    always_comb
    begin
        if (send_status_reg)
        begin
            record_kind   = sbf_pkg::REC_STATUS;
            struct_type   = '0;
            struct_offset = '0;
            struct_length = '0;
            status        = cur_reg.status;
            last_of_run   = 1'b1;
        end
        else
        begin
            record_kind   = sbf_pkg::REC_MATCH;
            struct_type   = cur_reg.struct_type;
            struct_offset = cur_reg.struct_offset;
            struct_length = cur_reg.struct_length;
            status        = sbf_pkg::ST_OK;
            last_of_run   = !cur_reg.has_status;
        end
    end

    // Output control: load a new entry or step to its status record
    always_comb
    begin
        valid_next       = valid_reg;
        send_status_next = send_status_reg;
        if (pop_ready)
        begin
            valid_next       = pop_valid;
            send_status_next = !pop_entry.has_match;
        end
        else if (fire)
        begin
            send_status_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= 1'b0;
            send_status_reg <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            send_status_reg <= send_status_next;
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
            cur_reg <= pop_entry;
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SMBIOS structure framer testbench
// Streams raw structure tables into the framer with random idle cycles on
// both sides. It predicts match and status records in a parse model of its
// own and checks every output transaction against them in order.
// ---------------------------------------------------------------------------
module testbench;

    // Table size limit, the framer's default
    localparam longint unsigned TABLE_LIMIT = sbf_pkg::MAX_TABLE_BYTES_DEF;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic              kind;
        logic [7:0]        stype;
        logic [15:0]       offset;
        logic [7:0]        slen;
        sbf_pkg::status_t  status;
        logic              last;
    } record_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = sbf_pkg::CFG_WANTED_TYPE;
    logic [7:0]  cfg_data = 8'd0;

    // Expected records, oldest first
    record_t expected_records[$];
    int      fail_count = 0;
    int      cycle_count = 0;
    int      sent_bytes = 0;
    bit      steady = 1'b0;

    // Table under construction
    logic [7:0] tbl[$];

    // Parse model state and its copy of the registers
    logic [7:0]        want_type;
    logic              want_enable;
    sbf_pkg::phase_t   parse_phase;
    int unsigned       parse_pos;
    logic [7:0]        fmt_left;
    logic [15:0]       cur_start;
    logic [7:0]        cur_type;
    logic [7:0]        cur_len;
    logic              prev_zero;
    sbf_pkg::status_t  table_status;

    smbios_structure_framer #(
        .MAX_TABLE_BYTES(TABLE_LIMIT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("smbios_structure_framer: mismatch");
            $finish;
        end
    end

    // Output backpressure
    always @(negedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(99) >= 28);
    end

    // Parse model
    task automatic clear_parse();
        parse_phase  = sbf_pkg::PH_TYPE;
        parse_pos    = 0;
        fmt_left     = 8'd0;
        cur_start    = 16'd0;
        cur_type     = 8'd0;
        cur_len      = 8'd0;
        prev_zero    = 1'b0;
        table_status = sbf_pkg::ST_OK;
    endtask

    task automatic report_struct(input logic closes_run);
        record_t r;
        if (want_enable && cur_type == want_type)
        begin
            r.kind   = sbf_pkg::REC_MATCH;
            r.stype  = cur_type;
            r.offset = cur_start;
            r.slen   = cur_len;
            r.status = sbf_pkg::ST_OK;
            r.last   = closes_run;
            expected_records.push_back(r);
        end
    endtask

    task automatic frame_byte(input logic [7:0] d, input logic last);
        logic    fmt_done;
        record_t r;
        fmt_done = 1'b0;
        sent_bytes++;
        if (table_status == sbf_pkg::ST_OK)
        begin
            if (parse_pos >= TABLE_LIMIT)
                table_status = sbf_pkg::ST_TOO_LONG;
            else
            begin
                case (parse_phase)
                    sbf_pkg::PH_TYPE:
                    begin
                        cur_start   = parse_pos[15:0];
                        cur_type    = d;
                        parse_phase = sbf_pkg::PH_LEN;
                    end
                    sbf_pkg::PH_LEN:
                    begin
                        cur_len = d;
                        if (d < sbf_pkg::HDR_LEN)
                            table_status = sbf_pkg::ST_SHORT_LEN;
                        else
                            parse_phase = sbf_pkg::PH_HLO;
                    end
                    sbf_pkg::PH_HLO:
                        parse_phase = sbf_pkg::PH_HHI;
                    sbf_pkg::PH_HHI, sbf_pkg::PH_FMT:
                    begin
                        if (parse_phase == sbf_pkg::PH_HHI)
                            fmt_left = cur_len - sbf_pkg::HDR_LEN;
                        else
                            fmt_left = fmt_left - 8'd1;
                        if (fmt_left == 8'd0)
                        begin
                            parse_phase = sbf_pkg::PH_STR;
                            prev_zero   = 1'b0;
                            fmt_done    = 1'b1;
                        end
                        else
                            parse_phase = sbf_pkg::PH_FMT;
                    end
                    sbf_pkg::PH_STR:
                    begin
                        if (d == 8'd0)
                        begin
                            // double zero closes the string set
                            if (prev_zero)
                            begin
                                report_struct(!last);
                                parse_phase = sbf_pkg::PH_TYPE;
                                prev_zero   = 1'b0;
                            end
                            else
                                prev_zero = 1'b1;
                        end
                        else
                            prev_zero = 1'b0;
                    end
                    default:
                        parse_phase = sbf_pkg::PH_TYPE;
                endcase
                parse_pos++;
            end
        end
        if (last)
        begin
            // table end: formatted area just finished counts as complete
            if (table_status == sbf_pkg::ST_OK && parse_phase != sbf_pkg::PH_TYPE)
            begin
                if (fmt_done)
                    report_struct(1'b0);
                else
                    table_status = sbf_pkg::ST_TRUNC;
            end
            r.kind   = sbf_pkg::REC_STATUS;
            r.stype  = 8'd0;
            r.offset = 16'd0;
            r.slen   = 8'd0;
            r.status = table_status;
            r.last   = 1'b1;
            expected_records.push_back(r);
            clear_parse();
        end
    endtask

    // Output check, then input prediction and register tracking
    always @(posedge clk)
    begin
        record_t r;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_records.size() == 0)
                begin
                    $error("unexpected record: kind %0d tdata %h", m_axis_tuser, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    r = expected_records.pop_front();
                    if (m_axis_tuser !== r.kind)
                    begin
                        $error("record_kind: expected %0d, actual %0d", r.kind, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[7:0] !== r.stype)
                    begin
                        $error("struct_type: expected %0d, actual %0d",
                               r.stype, m_axis_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[23:8] !== r.offset)
                    begin
                        $error("struct_offset: expected %0d, actual %0d",
                               r.offset, m_axis_tdata[23:8]);
                        fail_count++;
                    end
                    if (m_axis_tdata[31:24] !== r.slen)
                    begin
                        $error("struct_length: expected %0d, actual %0d",
                               r.slen, m_axis_tdata[31:24]);
                        fail_count++;
                    end
                    if (m_axis_tdata[33:32] !== r.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               r.status, m_axis_tdata[33:32]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== r.last)
                    begin
                        $error("last_of_run: expected %0d, actual %0d", r.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                frame_byte(s_axis_tdata, s_axis_tlast);
            if (cfg_wr_en)
            begin
                if (cfg_index == sbf_pkg::CFG_WANTED_TYPE)
                    want_type = cfg_data;
                else
                    want_enable = cfg_data[0];
            end
        end
    end

    // One input transaction, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(99) < 28)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_table();
        int i;
        for (i = 0; i < tbl.size(); i++)
            send_byte(tbl[i], i == tbl.size() - 1);
        tbl.delete();
    endtask

    // Wait until every expected record has come and the framer is quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_records.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write both registers on consecutive cycles
    task automatic write_regs(input logic [7:0] wtype, input logic wen);
        cfg_wr_en <= 1'b1;
        cfg_index <= sbf_pkg::CFG_WANTED_TYPE;
        cfg_data  <= wtype;
        @(negedge clk);
        cfg_index <= sbf_pkg::CFG_MATCH_EN;
        cfg_data  <= {7'd0, wen};
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Append one structure; with_strings = 0 stops after the formatted area
    task automatic add_struct(input logic [7:0] stype, input logic [7:0] slen,
                              input bit with_strings);
        int i;
        int j;
        int nstr;
        tbl.push_back(stype);
        tbl.push_back(slen);
        tbl.push_back(8'($urandom_range(255)));
        tbl.push_back(8'($urandom_range(255)));
        for (i = 4; i < slen; i++)
            tbl.push_back(8'($urandom_range(255)));
        if (with_strings)
        begin
            nstr = $urandom_range(3);
            if (nstr == 0)
                tbl.push_back(8'd0);
            for (i = 0; i < nstr; i++)
            begin
                for (j = $urandom_range(5, 1); j > 0; j--)
                    tbl.push_back(8'($urandom_range(255, 1)));
                tbl.push_back(8'd0);
            end
            tbl.push_back(8'd0);
        end
    endtask

    // Mostly well-formed tables, some cut, corrupted or pure noise
    task automatic random_table(input logic [7:0] wtype);
        int s;
        int mode;
        int keep;
        logic [7:0] stype;
        logic [7:0] slen;
        for (s = $urandom_range(3, 1); s > 0; s--)
        begin
            stype = ($urandom_range(99) < 45) ? wtype : 8'($urandom_range(255));
            slen  = ($urandom_range(99) < 6) ? 8'($urandom_range(255))
                                              : 8'($urandom_range(14, 4));
            add_struct(stype, slen, 1'b1);
        end
        mode = $urandom_range(99);
        if (mode >= 60 && mode < 70)
            add_struct(wtype, 8'($urandom_range(10, 4)), 1'b0);
        else if (mode >= 70 && mode < 80)
        begin
            keep = $urandom_range(tbl.size(), 1);
            tbl = tbl[0:keep-1];
        end
        else if (mode >= 80 && mode < 90)
            tbl[1] = 8'($urandom_range(3));
        else if (mode >= 90)
        begin
            tbl.delete();
            repeat ($urandom_range(24, 1)) tbl.push_back(8'($urandom_range(255)));
        end
        send_table();
    endtask

    // Hand-built tables for each end condition
    task automatic test_directed();
        write_regs(8'h11, 1'b1);
        // length-4 match with no strings, then one ending at its header
        tbl = {8'h11, 8'h04, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h11, 8'h04, 8'hFF, 8'h00};
        send_table();
        // length below 4, trailing byte ignored
        tbl = {8'h11, 8'h03, 8'h55};
        send_table();
        // table ends inside the string set
        tbl = {8'h22, 8'h04, 8'h01, 8'h00, 8'h41};
        send_table();
        // one-byte table
        tbl = {8'h00};
        send_table();
        // length zero on the last byte
        tbl = {8'h11, 8'h00};
        send_table();
        settle();
    endtask

    // Random traffic under several register settings
    task automatic test_random_traffic();
        int p;
        int start;
        logic [7:0] wtype;
        logic wen;
        for (p = 0; p < 4; p++)
        begin
            case (p)
                0: begin wtype = 8'($urandom_range(255)); wen = 1'b1; end
                1: begin wtype = 8'h00; wen = 1'b1; end
                2: begin wtype = 8'hFF; wen = 1'b1; end
                default: begin wtype = 8'($urandom_range(255)); wen = 1'b0; end
            endcase
            write_regs(wtype, wen);
            // one phase runs with no idle cycles on either side
            steady = (p == 2);
            start = sent_bytes;
            while (sent_bytes - start < 100)
                random_table(wtype);
            settle();
            steady = 1'b0;
        end
    endtask

    initial
    begin
        want_type   = 8'd0;
        want_enable = 1'b0;
        clear_parse();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random_traffic();
        if (fail_count == 0)
            $display("smbios_structure_framer: match");
        else
            $display("smbios_structure_framer: mismatch");
        $finish;
    end

endmodule
